// File: rtl/lcs_pkg.sv
`default_nettype none

package lcs_pkg;

  // pin positions of the data/command and enable lines
  localparam int unsigned RS_BIT = 4;
  localparam int unsigned EN_BIT = 5;

  localparam int unsigned PIN_W  = 7;
  localparam int unsigned HOLD_W = 17;
  localparam int unsigned STEP_W = 6;

  // request kinds
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_MOVE  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // microprogram entry points
  localparam logic [STEP_W-1:0] ENTRY_INIT  = 6'd0;
  localparam logic [STEP_W-1:0] ENTRY_CLEAR = 6'd43;
  localparam logic [STEP_W-1:0] ENTRY_DATA  = 6'd49;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // where the nibble of a pattern comes from
  typedef enum logic [1:0] {
    NS_CONST,
    NS_HI,
    NS_LO
  } nib_src_t;

  // hold time codes
  typedef enum logic [2:0] {
    H0,
    H10,
    H90,
    H170,
    H210,
    H4090,
    H10010,
    H100000
  } hold_t;

  typedef struct packed {
    nib_src_t   src;
    logic [3:0] nib;
    logic       en;
    hold_t      hold;
    logic       last;
  } ctrl_word_t;

endpackage

`default_nettype wire

// File: rtl/lcs_rom.sv
`default_nettype none

module lcs_rom
  import lcs_pkg::*;
(
  input  wire logic [STEP_W-1:0] step,
  output ctrl_word_t             word
);

  function automatic ctrl_word_t cw(nib_src_t src, logic [3:0] nib, logic en,
                                    hold_t hold, logic last);
    ctrl_word_t w;
    w.src  = src;
    w.nib  = nib;
    w.en   = en;
    w.hold = hold;
    w.last = last;
    return w;
  endfunction

  always_comb begin
    case (step)
      // power-on wait
      6'd0:  word = cw(NS_CONST, 4'h0, 1'b0, H100000, 1'b0);
      // reset nibbles
      6'd1:  word = cw(NS_CONST, 4'h3, 1'b0, H0,      1'b0);
      6'd2:  word = cw(NS_CONST, 4'h3, 1'b1, H10,     1'b0);
      6'd3:  word = cw(NS_CONST, 4'h3, 1'b0, H10010,  1'b0);
      6'd4:  word = cw(NS_CONST, 4'h3, 1'b0, H0,      1'b0);
      6'd5:  word = cw(NS_CONST, 4'h3, 1'b1, H10,     1'b0);
      6'd6:  word = cw(NS_CONST, 4'h3, 1'b0, H210,    1'b0);
      6'd7:  word = cw(NS_CONST, 4'h3, 1'b0, H0,      1'b0);
      6'd8:  word = cw(NS_CONST, 4'h3, 1'b1, H10,     1'b0);
      6'd9:  word = cw(NS_CONST, 4'h3, 1'b0, H210,    1'b0);
      6'd10: word = cw(NS_CONST, 4'h2, 1'b0, H0,      1'b0);
      6'd11: word = cw(NS_CONST, 4'h2, 1'b1, H10,     1'b0);
      6'd12: word = cw(NS_CONST, 4'h2, 1'b0, H90,     1'b0);
      // function set 0x28
      6'd13: word = cw(NS_CONST, 4'h2, 1'b0, H0,      1'b0);
      6'd14: word = cw(NS_CONST, 4'h2, 1'b1, H10,     1'b0);
      6'd15: word = cw(NS_CONST, 4'h2, 1'b0, H10,     1'b0);
      6'd16: word = cw(NS_CONST, 4'h8, 1'b0, H0,      1'b0);
      6'd17: word = cw(NS_CONST, 4'h8, 1'b1, H10,     1'b0);
      6'd18: word = cw(NS_CONST, 4'h8, 1'b0, H170,    1'b0);
      // display off 0x08
      6'd19: word = cw(NS_CONST, 4'h0, 1'b0, H0,      1'b0);
      6'd20: word = cw(NS_CONST, 4'h0, 1'b1, H10,     1'b0);
      6'd21: word = cw(NS_CONST, 4'h0, 1'b0, H10,     1'b0);
      6'd22: word = cw(NS_CONST, 4'h8, 1'b0, H0,      1'b0);
      6'd23: word = cw(NS_CONST, 4'h8, 1'b1, H10,     1'b0);
      6'd24: word = cw(NS_CONST, 4'h8, 1'b0, H170,    1'b0);
      // clear 0x01
      6'd25: word = cw(NS_CONST, 4'h0, 1'b0, H0,      1'b0);
      6'd26: word = cw(NS_CONST, 4'h0, 1'b1, H10,     1'b0);
      6'd27: word = cw(NS_CONST, 4'h0, 1'b0, H10,     1'b0);
      6'd28: word = cw(NS_CONST, 4'h1, 1'b0, H0,      1'b0);
      6'd29: word = cw(NS_CONST, 4'h1, 1'b1, H10,     1'b0);
      6'd30: word = cw(NS_CONST, 4'h1, 1'b0, H4090,   1'b0);
      // entry mode 0x06
      6'd31: word = cw(NS_CONST, 4'h0, 1'b0, H0,      1'b0);
      6'd32: word = cw(NS_CONST, 4'h0, 1'b1, H10,     1'b0);
      6'd33: word = cw(NS_CONST, 4'h0, 1'b0, H10,     1'b0);
      6'd34: word = cw(NS_CONST, 4'h6, 1'b0, H0,      1'b0);
      6'd35: word = cw(NS_CONST, 4'h6, 1'b1, H10,     1'b0);
      6'd36: word = cw(NS_CONST, 4'h6, 1'b0, H170,    1'b0);
      // display on 0x0c
      6'd37: word = cw(NS_CONST, 4'h0, 1'b0, H0,      1'b0);
      6'd38: word = cw(NS_CONST, 4'h0, 1'b1, H10,     1'b0);
      6'd39: word = cw(NS_CONST, 4'h0, 1'b0, H10,     1'b0);
      6'd40: word = cw(NS_CONST, 4'hc, 1'b0, H0,      1'b0);
      6'd41: word = cw(NS_CONST, 4'hc, 1'b1, H10,     1'b0);
      6'd42: word = cw(NS_CONST, 4'hc, 1'b0, H170,    1'b1);
      // clear request
      6'd43: word = cw(NS_CONST, 4'h0, 1'b0, H0,      1'b0);
      6'd44: word = cw(NS_CONST, 4'h0, 1'b1, H10,     1'b0);
      6'd45: word = cw(NS_CONST, 4'h0, 1'b0, H10,     1'b0);
      6'd46: word = cw(NS_CONST, 4'h1, 1'b0, H0,      1'b0);
      6'd47: word = cw(NS_CONST, 4'h1, 1'b1, H10,     1'b0);
      6'd48: word = cw(NS_CONST, 4'h1, 1'b0, H4090,   1'b1);
      // latched byte: move or write
      6'd49: word = cw(NS_HI,    4'h0, 1'b0, H0,      1'b0);
      6'd50: word = cw(NS_HI,    4'h0, 1'b1, H10,     1'b0);
      6'd51: word = cw(NS_HI,    4'h0, 1'b0, H10,     1'b0);
      6'd52: word = cw(NS_LO,    4'h0, 1'b0, H0,      1'b0);
      6'd53: word = cw(NS_LO,    4'h0, 1'b1, H10,     1'b0);
      6'd54: word = cw(NS_LO,    4'h0, 1'b0, H90,     1'b1);
      default: word = cw(NS_CONST, 4'h0, 1'b0, H0,    1'b1);
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lcs_datapath.sv
`default_nettype none

module lcs_datapath
  import lcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              capture,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        char_code,
  input  wire logic [1:0]        row,
  input  wire logic [5:0]        column,
  input  wire logic              load,
  input  wire ctrl_word_t        word,
  output logic [PIN_W-1:0]       port_pins,
  output logic [HOLD_W-1:0]      hold_us,
  output logic                   last
);

  localparam logic [PIN_W-1:0] RS_MASK = 7'd1 << RS_BIT;
  localparam logic [PIN_W-1:0] EN_MASK = 7'd1 << EN_BIT;

  logic [7:0]        data_byte;
  logic              rs_flag;
  logic [7:0]        addr;
  logic [3:0]        nib;
  logic [PIN_W-1:0]  pins;
  logic [HOLD_W-1:0] hold_val;

  // cursor address: 0x80 plus row offset plus column, wrapping modulo 256
  always_comb begin
    addr = 8'h80 | (row[0] ? 8'h40 : 8'h00) | (row[1] ? 8'h14 : 8'h00);
    addr = addr + {2'b00, column};
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      data_byte <= (op == OP_MOVE) ? addr : char_code;
      rs_flag   <= (op == OP_WRITE);
    end
  end

  always_comb begin
    case (word.src)
      NS_HI:   nib = data_byte[7:4];
      NS_LO:   nib = data_byte[3:0];
      default: nib = word.nib;
    endcase
    pins = {3'b000, nib};
    if ((word.src != NS_CONST) && rs_flag) pins = pins | RS_MASK;
    if (word.en) pins = pins | EN_MASK;
  end

  always_comb begin
    case (word.hold)
      H10:     hold_val = 17'd10;
      H90:     hold_val = 17'd90;
      H170:    hold_val = 17'd170;
      H210:    hold_val = 17'd210;
      H4090:   hold_val = 17'd4090;
      H10010:  hold_val = 17'd10010;
      H100000: hold_val = 17'd100000;
      default: hold_val = 17'd0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      port_pins <= pins;
      hold_us   <= hold_val;
      last      <= word.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcd_char_4bit_sequencer.sv
`default_nettype none

// character lcd sequencer, 4-bit bus
// input channel (in_valid/in_ready): one request with op, char_code, row,
// column. op selects init, clear, move cursor or write character.
// output channel (out_valid/out_ready): one pin pattern per transfer with
// port_pins, hold_us and last; last marks the final pattern of a request.
// a request runs as a microprogram held in a constant table: a step counter
// walks the table, each control word gives nibble source, enable pin, hold
// code and an end mark. the op picks the entry point.
// a taken request is latched and the sequencer enters run; the first pattern
// then enters the output register. throughput: one pattern per cycle while
// the receiver takes them; init has 43 patterns, clear, move and write have
// 6 patterns each.
// in_ready is high whenever no request is running, including while the last
// pattern of the previous run still sits in the output register.
// a stall on out_ready freezes the step counter and the output register;
// nothing is dropped.
// reset empties the output register and returns the sequencer to idle.

module lcd_char_4bit_sequencer
  import lcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        char_code,
  input  wire logic [1:0]        row,
  input  wire logic [5:0]        column,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIN_W-1:0]       port_pins,
  output logic [HOLD_W-1:0]      hold_us,
  output logic                   last
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              capture;
  logic              load;
  ctrl_word_t        word;

  // microcode table
  lcs_rom u_rom (
    .step (step),
    .word (word)
  );

  // request latch, pin assembly and output register
  lcs_datapath u_dp (
    .clk       (clk),
    .capture   (capture),
    .op        (op),
    .char_code (char_code),
    .row       (row),
    .column    (column),
    .load      (load),
    .word      (word),
    .port_pins (port_pins),
    .hold_us   (hold_us),
    .last      (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= ENTRY_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    in_ready       = 1'b0;
    capture        = 1'b0;
    load           = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // dispatch on request kind
          capture    = 1'b1;
          state_next = ST_RUN;
          case (op)
            OP_INIT:  step_next = ENTRY_INIT;
            OP_CLEAR: step_next = ENTRY_CLEAR;
            default:  step_next = ENTRY_DATA;
          endcase
        end
      end
      ST_RUN: begin
        // advance when the output register is free or being emptied
        if (!out_valid || out_ready) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          step_next      = step + 6'd1;
          if (word.last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
